// File: hw/rtl/mts_pkg.sv
// Shared types, constants and helpers for the markup tag stripper.
`default_nettype none
package mts_pkg;

  localparam int POS_W      = 16;
  localparam int BUF_DEPTH  = 9;
  localparam int CNT_W      = $clog2(BUF_DEPTH + 1);
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_COLOUR = '0;
  localparam logic [31:0] DEFAULT_COLOUR_RST = 32'hFFFF_FFFF;

  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_RBR  = 8'h5D;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_F    = 8'h66;
  localparam logic [7:0] CH_D    = 8'h64;
  localparam logic [7:0] CH_E    = 8'h65;
  localparam logic [7:0] CH_U    = 8'h75;

  // "[#uline]", index 0 first
  localparam logic [0:7][7:0] ULINE_PAT = {CH_LBR, CH_HASH, 8'h75, 8'h6C,
                                           8'h69, 8'h6E, 8'h65, CH_RBR};

  localparam logic [CNT_W-1:0] LEN_PLAIN  = CNT_W'(1);
  localparam logic [CNT_W-1:0] LEN_END    = CNT_W'(4);
  localparam logic [CNT_W-1:0] LEN_ULINE  = CNT_W'(8);
  localparam logic [CNT_W-1:0] LEN_COLOUR = CNT_W'(9);

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_REC   = 2'd1,
    KIND_SUM   = 2'd2
  } kind_t;

  typedef struct packed {
    logic ustop;
    logic ustart;
    logic cstop;
    logic cstart;
  } rec_flags_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_out;
    logic [15:0] position;
    rec_flags_t  flags;
    logic [31:0] tag_colour;
    logic [15:0] tags_found;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_EMIT_REC,
    OP_EMIT_PLAIN,
    OP_APPLY,
    OP_EMIT_SUM,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic append;
  } cmd_t;

  typedef struct packed {
    logic             empty;
    logic             open;
    logic             tag;
    logic             rec_pending;
    logic             push_ok;
    logic             stg_valid;
    logic [CNT_W-1:0] count;
  } stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_A) && (c <= CH_F));
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    return (c <= CH_9) ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mts_in_if.sv
// Input channel: one byte or end-of-string marker per transaction.
`default_nettype none
interface mts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_string;

  modport source (output valid, char_in, end_of_string, input ready);
  modport sink   (input valid, char_in, end_of_string, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mts_out_if.sv
// Result channel: plain byte, tag record or end summary per transaction.
`default_nettype none
interface mts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  char_out;
  logic [15:0] position;
  logic        colour_start;
  logic        colour_stop;
  logic        underline_start;
  logic        underline_stop;
  logic [31:0] tag_colour;
  logic [15:0] tags_found;
  logic        last;

  modport source (output valid, kind, char_out, position, colour_start, colour_stop,
                  underline_start, underline_stop, tag_colour, tags_found, last,
                  input ready);
  modport sink   (input valid, kind, char_out, position, colour_start, colour_stop,
                  underline_start, underline_stop, tag_colour, tags_found, last,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/mts_dpath.sv
// Datapath: held-byte shift line, tag matcher, record state, result stage.
`default_nettype none
module mts_dpath (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire mts_pkg::cmd_t  cmd,
  input  wire logic [7:0]     in_char,
  input  wire logic [31:0]    dflt_colour,
  output mts_pkg::stat_t      stat,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mts_pkg::result_t    out_item
);

  logic [mts_pkg::BUF_DEPTH-1:0][7:0] buf_r, buf_nxt;
  logic [mts_pkg::CNT_W-1:0]          count_r, count_nxt;
  logic                               rec_pending_r, rec_pending_nxt;
  mts_pkg::rec_flags_t                flags_r, flags_nxt;
  logic [31:0]                        colour_r, colour_nxt;
  logic [mts_pkg::POS_W-1:0]          pos_r, pos_nxt;
  logic [15:0]                        tag_total_r, tag_total_nxt;
  mts_pkg::result_t                   stg_r, stg_nxt;
  logic                               stg_valid_r, stg_valid_nxt;
  mts_pkg::result_t                   out_r, out_nxt;
  logic                               out_valid_r, out_valid_nxt;

  logic [mts_pkg::BUF_DEPTH-1:0] chk_col, chk_uln, chk_end;
  logic ok_col, ok_uln, ok_end;
  logic full_col, full_uln, full_end;
  logic push_ok;

  // Pattern match of the held bytes against each tag, only over filled entries
  always_comb begin
    logic       in_n;
    logic [7:0] c;
    logic       f_col, f_uln, f_end;
    for (int i = 0; i < mts_pkg::BUF_DEPTH; i++) begin
      in_n = (mts_pkg::CNT_W'(i) < count_r);
      c    = buf_r[i];
      if (i == 0) begin
        f_col = (c == mts_pkg::CH_LBR);
      end else if (i == 1) begin
        f_col = (c == mts_pkg::CH_HASH);
      end else if (i < 8) begin
        f_col = mts_pkg::is_hex(c);
      end else begin
        f_col = (c == mts_pkg::CH_RBR);
      end
      f_uln = (i < 8) ? (c == mts_pkg::ULINE_PAT[i % 8]) : 1'b1;
      if (i == 0) begin
        f_end = (c == mts_pkg::CH_LBR);
      end else if (i == 1) begin
        f_end = (c == mts_pkg::CH_HASH);
      end else if (i == 2) begin
        f_end = (c == mts_pkg::CH_D) || (c == mts_pkg::CH_U) || (c == mts_pkg::CH_E);
      end else if (i == 3) begin
        f_end = (c == mts_pkg::CH_RBR);
      end else begin
        f_end = 1'b1;
      end
      chk_col[i] = !in_n || f_col;
      chk_uln[i] = !in_n || f_uln;
      chk_end[i] = !in_n || f_end;
    end
  end

  assign ok_col   = &chk_col;
  assign ok_uln   = &chk_uln;
  assign ok_end   = &chk_end;
  assign full_col = ok_col && (count_r >= mts_pkg::LEN_COLOUR);
  assign full_uln = ok_uln && (count_r >= mts_pkg::LEN_ULINE);
  assign full_end = ok_end && (count_r >= mts_pkg::LEN_END);

  assign push_ok = !stg_valid_r || !out_valid_r || out_ready;

  always_comb begin
    stat             = '0;
    stat.empty       = (count_r == '0);
    stat.tag         = full_col || full_uln || full_end;
    stat.open        = !stat.tag && (ok_col || ok_uln || ok_end);
    stat.rec_pending = rec_pending_r;
    stat.push_ok     = push_ok;
    stat.stg_valid   = stg_valid_r;
    stat.count       = count_r;
  end

  always_comb begin
    logic [mts_pkg::CNT_W-1:0] shamt;
    logic                      push;
    logic                      finish;
    mts_pkg::result_t          new_item;
    mts_pkg::rec_flags_t       f;
    logic [31:0]               col;
    logic [7:0]                b2;

    buf_nxt         = buf_r;
    count_nxt       = count_r;
    rec_pending_nxt = rec_pending_r;
    flags_nxt       = flags_r;
    colour_nxt      = colour_r;
    pos_nxt         = pos_r;
    tag_total_nxt   = tag_total_r;
    stg_nxt         = stg_r;
    stg_valid_nxt   = stg_valid_r;
    out_nxt         = out_r;
    out_valid_nxt   = out_valid_r && !out_ready;

    shamt    = '0;
    push     = 1'b0;
    finish   = 1'b0;
    new_item = '0;
    new_item.position = 16'(pos_r);
    f   = rec_pending_r ? flags_r : '0;
    col = rec_pending_r ? colour_r : '0;
    b2  = buf_r[2];

    case (cmd.op)
      mts_pkg::OP_EMIT_REC: begin
        new_item.kind       = mts_pkg::KIND_REC;
        new_item.flags      = flags_r;
        new_item.tag_colour = colour_r;
        push                = 1'b1;
        rec_pending_nxt     = 1'b0;
      end
      mts_pkg::OP_EMIT_PLAIN: begin
        new_item.kind     = mts_pkg::KIND_PLAIN;
        new_item.char_out = buf_r[0];
        push              = 1'b1;
        pos_nxt           = pos_r + 1'b1;
        shamt             = mts_pkg::LEN_PLAIN;
      end
      mts_pkg::OP_APPLY: begin
        if (full_col) begin
          f.cstart = 1'b1;
          col      = {mts_pkg::hex_nibble(buf_r[2]), mts_pkg::hex_nibble(buf_r[3]),
                      mts_pkg::hex_nibble(buf_r[4]), mts_pkg::hex_nibble(buf_r[5]),
                      mts_pkg::hex_nibble(buf_r[6]), mts_pkg::hex_nibble(buf_r[7]),
                      dflt_colour[7:0]};
          shamt    = mts_pkg::LEN_COLOUR;
        end else if (full_uln) begin
          f.ustart = 1'b1;
          shamt    = mts_pkg::LEN_ULINE;
        end else begin
          if ((b2 == mts_pkg::CH_D) || (b2 == mts_pkg::CH_E)) begin
            f.cstart = 1'b0;
            f.cstop  = 1'b1;
            col      = dflt_colour;
          end
          if ((b2 == mts_pkg::CH_U) || (b2 == mts_pkg::CH_E)) begin
            f.ustart = 1'b0;
            f.ustop  = 1'b1;
          end
          shamt = mts_pkg::LEN_END;
        end
        flags_nxt       = f;
        colour_nxt      = col;
        rec_pending_nxt = 1'b1;
        tag_total_nxt   = tag_total_r + 1'b1;
      end
      mts_pkg::OP_EMIT_SUM: begin
        new_item.kind       = mts_pkg::KIND_SUM;
        new_item.tags_found = tag_total_r;
        push                = 1'b1;
        pos_nxt             = '0;
        tag_total_nxt       = '0;
        rec_pending_nxt     = 1'b0;
        count_nxt           = '0;
      end
      mts_pkg::OP_FINISH: begin
        finish = 1'b1;
      end
      default: begin
      end
    endcase

    if (shamt != '0) begin
      buf_nxt   = buf_r >> {shamt, 3'b000};
      count_nxt = count_r - shamt;
    end
    if (cmd.append) begin
      buf_nxt[count_r] = in_char;
      count_nxt        = count_r + 1'b1;
    end

    // Results wait in the stage until the next one arrives, so the last one can be marked
    if (push) begin
      if (stg_valid_r) begin
        out_nxt       = stg_r;
        out_valid_nxt = 1'b1;
      end
      stg_nxt       = new_item;
      stg_valid_nxt = 1'b1;
    end
    if (finish && stg_valid_r) begin
      out_nxt       = stg_r;
      out_nxt.last  = 1'b1;
      out_valid_nxt = 1'b1;
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      rec_pending_r <= 1'b0;
      pos_r         <= '0;
      tag_total_r   <= '0;
      stg_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      count_r       <= count_nxt;
      rec_pending_r <= rec_pending_nxt;
      pos_r         <= pos_nxt;
      tag_total_r   <= tag_total_nxt;
      stg_valid_r   <= stg_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r    <= buf_nxt;
    flags_r  <= flags_nxt;
    colour_r <= colour_nxt;
    stg_r    <= stg_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

// File: hw/rtl/mts_ctrl.sv
// Controller: sequences scan steps over the held bytes, one per cycle unless a result must wait for the output.
`default_nettype none
module mts_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_eos,
  output logic                in_ready,
  input  wire mts_pkg::stat_t stat,
  output mts_pkg::cmd_t       cmd
);

  mts_pkg::state_t state_r, state_nxt;
  logic            final_r, final_nxt;
  logic            plain_case;

  // head goes out as a plain byte: no tag there, and no open prefix to wait on or the string has ended
  assign plain_case = !stat.empty && !stat.tag && (!stat.open || final_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mts_pkg::ST_IDLE;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      final_r <= final_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    final_nxt  = final_r;
    in_ready   = 1'b0;
    cmd.op     = mts_pkg::OP_NONE;
    cmd.append = 1'b0;
    case (state_r)
      mts_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt  = mts_pkg::ST_SCAN;
          final_nxt  = in_eos;
          cmd.append = !in_eos;
        end
      end
      mts_pkg::ST_SCAN: begin
        if (stat.tag) begin
          cmd.op = mts_pkg::OP_APPLY;
        end else if (plain_case) begin
          if (stat.push_ok) begin
            cmd.op = stat.rec_pending ? mts_pkg::OP_EMIT_REC : mts_pkg::OP_EMIT_PLAIN;
          end
        end else if (final_r) begin
          if (stat.push_ok) begin
            if (stat.rec_pending) begin
              cmd.op = mts_pkg::OP_EMIT_REC;
            end else begin
              cmd.op    = mts_pkg::OP_EMIT_SUM;
              final_nxt = 1'b0;
            end
          end
        end else if (stat.push_ok) begin
          // scan done: release the last result and take the next transaction
          cmd.op   = mts_pkg::OP_FINISH;
          in_ready = 1'b1;
          if (in_valid) begin
            final_nxt  = in_eos;
            cmd.append = !in_eos;
          end else begin
            state_nxt = mts_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = mts_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/markup_tag_stripper.sv
// Each result passes the result stage, then the output register, to out_ch. A new
// transaction is taken only when the scan of the last is done. A tag or a failed
// candidate adds scan steps (tag applied, byte re-emitted, record flushed), run by the
// single scan unit on the 9-entry held-byte shift line; end of string adds the summary step.
// Reset: synchronous active-low rst_n; stream state cleared, default colour
// set to all ones, held bytes left as they are (never read before written).
`default_nettype none
module markup_tag_stripper (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mts_in_if.sink                               in_ch,
  mts_out_if.source                            out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mts_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [31:0]                     dflt_colour_r, dflt_colour_nxt;
  logic [mts_pkg::REG_IDX_W-1:0]   reg_idx;
  mts_pkg::cmd_t                   cmd;
  mts_pkg::stat_t                  stat;
  logic                            out_valid;
  mts_pkg::result_t                out_item;

  // Config register: single word, written in the access phase of an APB write
  assign pready  = 1'b1;
  assign reg_idx = paddr[mts_pkg::CFG_ADDR_W-1:2];

  always_comb begin
    dflt_colour_nxt = dflt_colour_r;
    if (psel && penable && pwrite && (reg_idx == mts_pkg::REG_DEFAULT_COLOUR)) begin
      dflt_colour_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_colour_r <= mts_pkg::DEFAULT_COLOUR_RST;
    end else begin
      dflt_colour_r <= dflt_colour_nxt;
    end
  end

  assign prdata = (reg_idx == mts_pkg::REG_DEFAULT_COLOUR) ? dflt_colour_r : '0;

  // Controller decides each scan step from datapath status
  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_eos   (in_ch.end_of_string),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath holds the bytes of an open tag candidate and the result stage
  mts_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_char     (in_ch.char_in),
    .dflt_colour (dflt_colour_r),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ch.ready),
    .out_item    (out_item)
  );

  assign out_ch.valid           = out_valid;
  assign out_ch.kind            = out_item.kind;
  assign out_ch.char_out        = out_item.char_out;
  assign out_ch.position        = out_item.position;
  assign out_ch.colour_start    = out_item.flags.cstart;
  assign out_ch.colour_stop     = out_item.flags.cstop;
  assign out_ch.underline_start = out_item.flags.ustart;
  assign out_ch.underline_stop  = out_item.flags.ustop;
  assign out_ch.tag_colour      = out_item.tag_colour;
  assign out_ch.tags_found      = out_item.tags_found;
  assign out_ch.last            = out_item.last;

`ifndef NO_ASSERTIONS
  // an end summary closes its transaction's results
  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.kind == mts_pkg::KIND_SUM)) |-> out_ch.last)
    else $error("summary result without last");

  // a tag record always carries at least one flag
  a_rec_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.kind == mts_pkg::KIND_REC)) |->
      (out_ch.colour_start || out_ch.colour_stop ||
       out_ch.underline_start || out_ch.underline_stop))
    else $error("tag record with no flags");

  // a new transaction only lands while at most an open prefix is held
  a_held_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> (stat.count <= mts_pkg::CNT_W'(8)))
    else $error("held bytes overflow on accept");

  // previous transaction's results are all released when a new one is taken
  a_stage_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !stat.stg_valid)
    else $error("result stage still loaded after accept");
`endif

endmodule
`default_nettype wire
